// ----- rtl/core/tcn_pkg.sv -----
// Shared constants and a helper function of the tab column note event generator.
package tcn_pkg;

   // Parameter defaults
   localparam int MAX_LANES_DEF = 8;
   localparam int TICK_BITS_DEF = 16;

   // Number of lane character ports on the request channel
   localparam int LANE_PORTS = 8;

   // Widths fixed by the field definitions
   localparam int CHAR_W  = 8;
   localparam int PITCH_W = 9;
   localparam int BASE_W  = 7;
   localparam int LANE_W  = 3;
   localparam int OUT_TICK_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 63;

   // Request opcodes
   localparam logic OP_COLUMN = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LANE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRUM_MODE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_NOTES = 2'd2;

   // Register reset values: six-string standard tuning
   localparam logic [3:0]            LANE_COUNT_RST = 4'd6;
   localparam logic                  DRUM_MODE_RST  = 1'b0;
   localparam logic [CSR_DATA_W-1:0] BASE_NOTES_RST = 63'h0000_282D_3237_3B40;

   // Tablature characters
   localparam logic [CHAR_W-1:0] CHAR_REST      = 8'h2D; // '-'
   localparam logic [CHAR_W-1:0] CHAR_STOP      = 8'h78; // 'x'
   localparam logic [CHAR_W-1:0] CHAR_DRUM_STOP = 8'h7A; // 'z'
   localparam logic [CHAR_W-1:0] CHAR_BAR       = 8'h7C; // '|'
   localparam logic [CHAR_W-1:0] CHAR_STACCATO  = 8'h2E; // '.'
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0   = 8'h30; // '0'
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9   = 8'h39; // '9'
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A   = 8'h41; // 'A'
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z   = 8'h5A; // 'Z'
   localparam logic [CHAR_W-1:0] LETTER_OFFSET  = 8'd10;

   // Fret value of a character, two's complement: digits, then letters, else minus one
   function automatic logic [PITCH_W-1:0] fret_value(input logic [CHAR_W-1:0] c);
      logic [PITCH_W-1:0] v;
      v = '1;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         v = PITCH_W'(c - CHAR_DIGIT_0);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         v = PITCH_W'(c - CHAR_UPPER_A + LETTER_OFFSET);
      end
      return v;
   endfunction

endpackage

// ----- rtl/core/tab_column_note_event_generator.sv -----
// Top level of the tab column note event generator.
//
// One request beat carries one tablature column (a character per lane plus the palm-mute
// character) or, with req_op high, an end-of-tab flush. The column is captured in an item
// register; short logic then works out every event of the column at once (for each lane in
// use a possible note-off followed by a possible note-on, lanes in ascending order), and an
// emit stage hands them to the response register one beat per cycle while rsp_ready allows,
// lowest lane first. A column has at most two events per lane, so at most sixteen with the
// default lane limit. A column with no events retires as soon as it is held, and the next
// request is taken in the cycle the previous column sends its final event, so back-to-back
// columns with events keep the response channel busy without gaps. The first event of a
// column passes through the item register and then the response register before it appears
// on rsp_. rsp_last marks the final event of a column. Lane and tick state is updated when a
// column retires; a flush sends a note-off for every lane in use and clears all lane state
// and the tick counters. There is no clearing pass after reset. Registers are written
// through the csr_ port, which is always ready; write them only while no column is in flight.
module tab_column_note_event_generator #(
   parameter int MAX_LANES = tcn_pkg::MAX_LANES_DEF,
   parameter int TICK_BITS = tcn_pkg::TICK_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tcn_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tcn_pkg::CSR_DATA_W-1:0]        csr_data,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [tcn_pkg::CHAR_W-1:0]            req_lane0_char,
   input  logic [tcn_pkg::CHAR_W-1:0]            req_lane1_char,
   input  logic [tcn_pkg::CHAR_W-1:0]            req_lane2_char,
   input  logic [tcn_pkg::CHAR_W-1:0]            req_lane3_char,
   input  logic [tcn_pkg::CHAR_W-1:0]            req_lane4_char,
   input  logic [tcn_pkg::CHAR_W-1:0]            req_lane5_char,
   input  logic [tcn_pkg::CHAR_W-1:0]            req_lane6_char,
   input  logic [tcn_pkg::CHAR_W-1:0]            req_lane7_char,
   input  logic [tcn_pkg::CHAR_W-1:0]            req_mute_char,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [tcn_pkg::OUT_TICK_W-1:0]        rsp_tick,
   output logic [tcn_pkg::LANE_W-1:0]            rsp_lane,
   output logic                                  rsp_note_on,
   output logic signed [tcn_pkg::PITCH_W-1:0]    rsp_pitch,
   output logic                                  rsp_staccato,
   output logic                                  rsp_last
);

   // Two event slots per lane: even slot note-off, odd slot note-on
   localparam int SLOTS = 2 * MAX_LANES;

   // ---------------------------------------------------------------- configuration
   logic [3:0]                         lane_count_ff;
   logic                               drum_mode_ff;
   logic [tcn_pkg::CSR_DATA_W-1:0]     base_notes_ff;
   logic [3:0]                         lanes_used;

   assign csr_ready = 1'b1;

   // Zero lanes acts as one, anything above the lane limit as the limit
   always_comb begin
      if (lane_count_ff == 4'd0) begin
         lanes_used = 4'd1;
      end else if (lane_count_ff > 4'(MAX_LANES)) begin
         lanes_used = 4'(MAX_LANES);
      end else begin
         lanes_used = lane_count_ff;
      end
   end

   // ---------------------------------------------------------------- item register
   logic [tcn_pkg::CHAR_W-1:0] req_char [tcn_pkg::LANE_PORTS];

   assign req_char[0] = req_lane0_char;
   assign req_char[1] = req_lane1_char;
   assign req_char[2] = req_lane2_char;
   assign req_char[3] = req_lane3_char;
   assign req_char[4] = req_lane4_char;
   assign req_char[5] = req_lane5_char;
   assign req_char[6] = req_lane6_char;
   assign req_char[7] = req_lane7_char;

   logic                        item_valid_ff;
   logic                        item_op_ff;
   logic [tcn_pkg::CHAR_W-1:0]  item_char_ff [MAX_LANES];
   logic [tcn_pkg::CHAR_W-1:0]  item_mute_ff;
   logic [SLOTS-1:0]            done_ff;      // slots of the held item already sent

   // ---------------------------------------------------------------- lane and tick state
   logic [tcn_pkg::PITCH_W-1:0] last_pitch_ff [MAX_LANES];
   logic [MAX_LANES-1:0]        last_stac_ff;
   logic [MAX_LANES-1:0]        playing_ff;
   logic [TICK_BITS-1:0]        column_count_ff;
   logic [TICK_BITS-1:0]        bar_count_ff;

   // ---------------------------------------------------------------- event slots
   logic [SLOTS-1:0]            slot_valid;
   logic [tcn_pkg::PITCH_W-1:0] slot_pitch [SLOTS];
   logic [SLOTS-1:0]            slot_stac;
   logic [MAX_LANES-1:0]        lane_new;
   logic [tcn_pkg::PITCH_W-1:0] new_pitch [MAX_LANES];
   logic                        col_stac;
   logic                        bar_hit;

   always_comb begin
      logic [tcn_pkg::CHAR_W-1:0]  c;
      logic [tcn_pkg::CHAR_W-1:0]  stop_char;
      logic [tcn_pkg::PITCH_W-1:0] base;
      logic                        in_use;
      logic                        is_rest;
      logic                        is_stop;
      logic                        is_bar;
      stop_char  = drum_mode_ff ? tcn_pkg::CHAR_DRUM_STOP : tcn_pkg::CHAR_STOP;
      col_stac   = drum_mode_ff | (item_mute_ff == tcn_pkg::CHAR_STACCATO);
      bar_hit    = 1'b0;
      slot_valid = '0;
      slot_stac  = '0;
      lane_new   = '0;
      for (int i = 0; i < MAX_LANES; i++) begin
         c       = item_char_ff[i];
         base    = {2'b00, base_notes_ff[8*i +: tcn_pkg::BASE_W]};
         in_use  = (4'(i) < lanes_used);
         is_rest = (c == tcn_pkg::CHAR_REST);
         is_stop = (c == stop_char);
         is_bar  = (c == tcn_pkg::CHAR_BAR);

         new_pitch[i] = drum_mode_ff ? base : base + tcn_pkg::fret_value(c);

         slot_pitch[2*i]   = last_pitch_ff[i];
         slot_stac[2*i]    = last_stac_ff[i];
         slot_pitch[2*i+1] = new_pitch[i];
         slot_stac[2*i+1]  = col_stac;

         if (item_op_ff == tcn_pkg::OP_FLUSH) begin
            slot_valid[2*i] = in_use;
         end else begin
            lane_new[i]       = in_use & ~is_rest & ~is_stop & ~is_bar;
            slot_valid[2*i]   = in_use & (is_stop | (lane_new[i] & playing_ff[i]));
            slot_valid[2*i+1] = lane_new[i];
            bar_hit           = bar_hit | (in_use & is_bar);
         end
      end
   end

   // ---------------------------------------------------------------- emit stage
   logic [SLOTS-1:0]            pending;
   logic [SLOTS-1:0]            pick;        // one-hot lowest pending slot
   logic                        pick_only;
   logic                        out_free;
   logic                        emit;
   logic                        retire;
   logic                        accept;
   logic [TICK_BITS-1:0]        tick_sel;
   logic [tcn_pkg::LANE_W-1:0]  sel_lane;
   logic                        sel_on;
   logic [tcn_pkg::PITCH_W-1:0] sel_pitch;
   logic                        sel_stac;

   assign pending   = item_valid_ff ? (slot_valid & ~done_ff) : '0;
   assign pick      = pending & (~pending + SLOTS'(1));
   assign pick_only = ((pending & ~pick) == '0);
   assign out_free  = ~rsp_valid | rsp_ready;
   assign emit      = (pending != '0) & out_free;
   // Retire once the final event moves out, or at once when the column has none
   assign retire    = item_valid_ff & ((pending == '0) | (emit & pick_only));
   assign req_ready = ~item_valid_ff | retire;
   assign accept    = req_valid & req_ready;

   assign tick_sel = (item_op_ff == tcn_pkg::OP_FLUSH) ? column_count_ff
                                                       : column_count_ff - bar_count_ff;

   // AND-OR select of the picked slot
   always_comb begin
      sel_lane  = '0;
      sel_on    = 1'b0;
      sel_pitch = '0;
      sel_stac  = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         sel_lane  = sel_lane  | ({tcn_pkg::LANE_W{pick[j]}} & tcn_pkg::LANE_W'(j >> 1));
         sel_on    = sel_on    | (pick[j] & 1'(j));
         sel_pitch = sel_pitch | ({tcn_pkg::PITCH_W{pick[j]}} & slot_pitch[j]);
         sel_stac  = sel_stac  | (pick[j] & slot_stac[j]);
      end
   end

   // ---------------------------------------------------------------- control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_count_ff   <= tcn_pkg::LANE_COUNT_RST;
         drum_mode_ff    <= tcn_pkg::DRUM_MODE_RST;
         base_notes_ff   <= tcn_pkg::BASE_NOTES_RST;
         item_valid_ff   <= 1'b0;
         done_ff         <= '0;
         rsp_valid       <= 1'b0;
         last_stac_ff    <= '0;
         playing_ff      <= '0;
         column_count_ff <= '0;
         bar_count_ff    <= '0;
         for (int i = 0; i < MAX_LANES; i++) begin
            last_pitch_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               tcn_pkg::CSR_LANE_COUNT: lane_count_ff <= csr_data[3:0];
               tcn_pkg::CSR_DRUM_MODE:  drum_mode_ff  <= csr_data[0];
               tcn_pkg::CSR_BASE_NOTES: base_notes_ff <= csr_data;
               default: ;
            endcase
         end

         // hold the item until its final event has gone out
         if (accept) begin
            item_valid_ff <= 1'b1;
         end else if (retire) begin
            item_valid_ff <= 1'b0;
         end

         if (accept) begin
            done_ff <= '0;
         end else if (emit) begin
            done_ff <= done_ff | pick;
         end

         if (emit) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end

         // advance lane and tick state as the column leaves
         if (retire) begin
            if (item_op_ff == tcn_pkg::OP_FLUSH) begin
               last_stac_ff    <= '0;
               playing_ff      <= '0;
               column_count_ff <= '0;
               bar_count_ff    <= '0;
               for (int i = 0; i < MAX_LANES; i++) begin
                  last_pitch_ff[i] <= '0;
               end
            end else begin
               for (int i = 0; i < MAX_LANES; i++) begin
                  if (lane_new[i]) begin
                     last_pitch_ff[i] <= new_pitch[i];
                     last_stac_ff[i]  <= col_stac;
                     playing_ff[i]    <= 1'b1;
                  end
               end
               bar_count_ff    <= bar_count_ff + TICK_BITS'(bar_hit);
               column_count_ff <= column_count_ff + TICK_BITS'(1);
            end
         end
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_op_ff   <= req_op;
         item_mute_ff <= req_mute_char;
         for (int i = 0; i < MAX_LANES; i++) begin
            item_char_ff[i] <= req_char[i];
         end
      end
      if (emit) begin
         rsp_tick     <= tcn_pkg::OUT_TICK_W'(tick_sel);
         rsp_lane     <= sel_lane;
         rsp_note_on  <= sel_on;
         rsp_pitch    <= sel_pitch;
         rsp_staccato <= sel_stac;
         rsp_last     <= pick_only;
      end
   end

endmodule

// ----- rtl/core/tcn_checker.sv -----
// Port-level assertions of the tab column note event generator, with their bind.
module tcn_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [tcn_pkg::PITCH_W-1:0]  rsp_pitch,
   input logic [tcn_pkg::OUT_TICK_W-1:0]      rsp_tick,
   input logic                                rsp_last
);

   // A stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pitch) && $stable(rsp_tick)
                                  && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // The only negative pitch is the invalid-fret value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pitch[8] |-> rsp_pitch == -9'sd1)
      else $error("negative pitch other than minus one");

   // Base plus largest fret bounds every pitch
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pitch[8] |-> rsp_pitch[7:0] <= 8'd162)
      else $error("pitch above base plus largest fret");

   // Nothing is offered straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind tab_column_note_event_generator tcn_checker u_tcn_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_pitch (rsp_pitch),
   .rsp_tick  (rsp_tick),
   .rsp_last  (rsp_last)
);
